// File: rtl/core/ppne_pkg.sv
// Package for the piecewise periodic next-event block.
// Holds the table sizes, time width, status codes and the table write bundle.
// No dependencies.
package ppne_pkg;

    localparam int TIME_W  = 48;
    localparam int SEG_CNT = 8;
    localparam int IDX_W   = (SEG_CNT > 1) ? $clog2(SEG_CNT) : 1;
    localparam int CNT_W   = $clog2(SEG_CNT + 1);
    localparam int DIVC_W  = $clog2(TIME_W + 1);

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] period;
    } t_seg_wr;

endpackage

// File: rtl/core/ppne_seg_mem.sv
// Segment table: start time and period for each stored segment.
// One write port and one registered read port; uses ppne_pkg.
module ppne_seg_mem (
    input  logic                         i_clk,
    input  ppne_pkg::t_seg_wr            i_wr,
    input  logic [ppne_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [ppne_pkg::TIME_W-1:0]  o_rd_start,
    output logic [ppne_pkg::TIME_W-1:0]  o_rd_period
);

    logic [ppne_pkg::TIME_W-1:0] r_start_mem  [ppne_pkg::SEG_CNT];
    logic [ppne_pkg::TIME_W-1:0] r_period_mem [ppne_pkg::SEG_CNT];
    logic [ppne_pkg::TIME_W-1:0] r_rd_start;
    logic [ppne_pkg::TIME_W-1:0] r_rd_period;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_start_mem[i_wr.addr]  <= i_wr.start;
            r_period_mem[i_wr.addr] <= i_wr.period;
        end
        r_rd_start  <= r_start_mem[i_rd_addr];
        r_rd_period <= r_period_mem[i_rd_addr];
    end

    assign o_rd_start  = r_rd_start;
    assign o_rd_period = r_rd_period;

endmodule

// File: rtl/core/ppne_rem_serial.sv
// Bit-serial remainder unit: the dividend shifts in one bit per cycle,
// restoring division of TIME_W-bit operands. Uses ppne_pkg.
module ppne_rem_serial (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ppne_pkg::TIME_W-1:0]  i_dividend,
    input  logic [ppne_pkg::TIME_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [ppne_pkg::TIME_W-1:0]  o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [ppne_pkg::DIVC_W-1:0]   r_cnt;
    logic [ppne_pkg::TIME_W-1:0]   r_shift;
    logic [ppne_pkg::TIME_W-1:0]   r_rem;
    logic [ppne_pkg::TIME_W-1:0]   r_div;
    logic [ppne_pkg::TIME_W:0]     trial;
    logic [ppne_pkg::TIME_W:0]     diff;

    always_comb begin
        trial = {r_rem, r_shift[ppne_pkg::TIME_W-1]};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == ppne_pkg::DIVC_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ppne_pkg::DIVC_W'(ppne_pkg::TIME_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - ppne_pkg::DIVC_W'(1);
                if (r_cnt == ppne_pkg::DIVC_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The partial remainder stays below the divisor, so it fits TIME_W bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[ppne_pkg::TIME_W-2:0], 1'b0};
            if (!diff[ppne_pkg::TIME_W]) begin
                r_rem <= diff[ppne_pkg::TIME_W-1:0];
            end else begin
                r_rem <= trial[ppne_pkg::TIME_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running operation");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
`endif

endmodule

// File: rtl/core/piecewise_periodic_next_event_top.sv
// Piecewise periodic next-event scheduler, top level.
// Sequencer, append checks and result path; uses ppne_pkg, ppne_seg_mem
// and ppne_rem_serial.
//
// Usage: one input channel (i_valid/o_ready) carries i_mode, i_time_value
// and i_period; one output channel (o_valid/i_ready) carries o_next_time,
// o_status and o_segment_index. Every input transaction gives exactly one
// output transaction, in order.
// An append (mode 0) checks the segment's time and period, its start against
// the last stored start and the table size, and stores it if it passes.
// A query (mode 1) walks the segment pointer forward past each stored
// segment that starts at or before t, reads the current segment, then finds
// the remainder of (t - start) / period in a bit-serial divider, forms the
// grid point t - remainder + period and clamps it to the next segment start.
// A query before the current segment start, or on an empty table, skips
// the divider.
// One item is in work at a time; o_ready is high only while the sequencer
// is idle. A finished result waits in the output register while the
// receiver stalls, and the block then holds its next result until the
// register is free.
// Reset (synchronous, active low) empties the segment table and sets the
// pointer to zero; table entries need no clearing.
module piecewise_periodic_next_event_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic signed [ppne_pkg::TIME_W-1:0]    i_time_value,
    input  logic signed [ppne_pkg::TIME_W-1:0]    i_period,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ppne_pkg::TIME_W-1:0]    o_next_time,
    output logic [1:0]                            o_status,
    output logic [2:0]                            o_segment_index
);

    localparam int W = ppne_pkg::TIME_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_APPEND   = 4'd1;
    localparam logic [3:0] ST_WALK_RD  = 4'd2;
    localparam logic [3:0] ST_WALK_CMP = 4'd3;
    localparam logic [3:0] ST_CUR_RD   = 4'd4;
    localparam logic [3:0] ST_CUR_CMP  = 4'd5;
    localparam logic [3:0] ST_DIV      = 4'd6;
    localparam logic [3:0] ST_SUM      = 4'd7;
    localparam logic [3:0] ST_CLAMP    = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    localparam logic [W-1:0] TMAXV = {1'b0, {(W-1){1'b1}}};

    logic [3:0]                     r_state, n_state;
    logic [ppne_pkg::CNT_W-1:0]     r_count, n_count;
    logic [ppne_pkg::IDX_W-1:0]     r_cur, n_cur;
    logic                           r_out_valid, n_out_valid;

    logic                           r_mode, n_mode;
    logic [W-1:0]                   r_t, n_t;
    logic [W-1:0]                   r_p, n_p;
    logic [W-1:0]                   r_last_start, n_last_start;
    logic [W-1:0]                   r_next_start, n_next_start;
    logic                           r_has_next, n_has_next;
    logic [W-1:0]                   r_res, n_res;
    logic [1:0]                     r_status, n_status;
    logic [W-1:0]                   r_out_next, n_out_next;
    logic [1:0]                     r_out_status, n_out_status;
    logic [ppne_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;

    ppne_pkg::t_seg_wr              seg_wr;
    logic [ppne_pkg::IDX_W-1:0]     rd_addr;
    logic [W-1:0]                   rd_start;
    logic [W-1:0]                   rd_period;
    logic                           div_start;
    logic                           div_done;
    logic [W-1:0]                   div_rem;

    logic [ppne_pkg::CNT_W-1:0]     cur_plus1;
    logic                           more_segs;
    logic                           bad_seg;
    logic [W:0]                     sum;
    logic [ppne_pkg::IDX_W+2:0]     idx_ext;

    ppne_seg_mem u_mem (
        .i_clk       (i_clk),
        .i_wr        (seg_wr),
        .i_rd_addr   (rd_addr),
        .o_rd_start  (rd_start),
        .o_rd_period (rd_period)
    );

    ppne_rem_serial u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_t - rd_start),
        .i_divisor  (rd_period),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        cur_plus1 = ppne_pkg::CNT_W'(r_cur) + ppne_pkg::CNT_W'(1);
        more_segs = cur_plus1 < r_count;
        bad_seg   = r_t[W-1] || r_p[W-1] || (r_p == '0) ||
                    ((r_count != '0) && ($signed(r_last_start) >= $signed(r_t)));
        // t >= r here, so the sum never goes negative and stays below 2^W.
        sum       = {1'b0, r_t} - {1'b0, div_rem} + {1'b0, r_p};
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_t          = r_t;
        n_p          = r_p;
        n_last_start = r_last_start;
        n_next_start = r_next_start;
        n_has_next   = r_has_next;
        n_res        = r_res;
        n_status     = r_status;
        n_out_next   = r_out_next;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        seg_wr.en     = 1'b0;
        seg_wr.addr   = r_count[ppne_pkg::IDX_W-1:0];
        seg_wr.start  = r_t;
        seg_wr.period = r_p;
        rd_addr      = r_cur;
        div_start    = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_t    = i_time_value;
                    n_p    = i_period;
                    n_res  = '0;
                    n_state = i_mode ? ST_WALK_RD : ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (bad_seg) begin
                    n_status = ppne_pkg::STAT_REJECTED;
                end else if (r_count >= ppne_pkg::CNT_W'(ppne_pkg::SEG_CNT)) begin
                    n_status = ppne_pkg::STAT_FULL;
                end else begin
                    n_status     = ppne_pkg::STAT_OK;
                    seg_wr.en    = 1'b1;
                    n_count      = r_count + ppne_pkg::CNT_W'(1);
                    n_last_start = r_t;
                end
                n_state = ST_OUT;
            end
            ST_WALK_RD: begin
                n_status = ppne_pkg::STAT_OK;
                if (r_count == '0) begin
                    n_status = ppne_pkg::STAT_EMPTY;
                    n_state  = ST_OUT;
                end else if (more_segs) begin
                    rd_addr = cur_plus1[ppne_pkg::IDX_W-1:0];
                    n_state = ST_WALK_CMP;
                end else begin
                    n_has_next = 1'b0;
                    n_state    = ST_CUR_RD;
                end
            end
            ST_WALK_CMP: begin
                if ($signed(r_t) >= $signed(rd_start)) begin
                    n_cur   = cur_plus1[ppne_pkg::IDX_W-1:0];
                    n_state = ST_WALK_RD;
                end else begin
                    n_next_start = rd_start;
                    n_has_next   = 1'b1;
                    n_state      = ST_CUR_RD;
                end
            end
            ST_CUR_RD: begin
                n_state = ST_CUR_CMP;
            end
            ST_CUR_CMP: begin
                if ($signed(r_t) < $signed(rd_start)) begin
                    n_res   = rd_start;
                    n_state = ST_OUT;
                end else begin
                    n_p       = rd_period;
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                // Saturate when the grid point passes the top of the signed range.
                n_res   = sum[W-1] ? TMAXV : sum[W-1:0];
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (r_has_next && (r_res > r_next_start)) begin
                    n_res = r_next_start;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_next   = r_res;
                    n_out_status = r_status;
                    n_out_idx    = r_cur;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_t          <= n_t;
        r_p          <= n_p;
        r_last_start <= n_last_start;
        r_next_start <= n_next_start;
        r_has_next   <= n_has_next;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_next   <= n_out_next;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
    end

    assign idx_ext         = {3'b000, r_out_idx};
    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_next_time     = $signed(r_out_next);
    assign o_status        = r_out_status;
    assign o_segment_index = idx_ext[2:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppne_pkg::CNT_W'(ppne_pkg::SEG_CNT))
        else $error("segment count beyond table size");
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (ppne_pkg::CNT_W'(r_cur) < r_count))
        else $error("segment pointer beyond stored segments");
    a_cur_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != $past(r_cur)) |-> ($past(r_state) == ST_WALK_CMP))
        else $error("segment pointer moved outside the walk");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("remainder finished outside the divide state");
    a_mode_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPEND) |-> !r_mode)
        else $error("append state entered for a query");
`endif

endmodule
